// File: src/edws_pkg.sv
`timescale 1ns / 1ps

package edws_pkg;

    localparam int MAX_LEN = 16;
    localparam int VAL_W   = $clog2(MAX_LEN + 1);
    localparam int CAND_W  = VAL_W + 2;
    localparam int CHAR_W  = 8;
    localparam int DIST_W  = 5;
    localparam int THR_W   = 5;

    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [CAND_W-1:0] t_cand;
    typedef logic [CHAR_W-1:0] t_char;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_APPEND_A = 2'd1,
        CMD_APPEND_B = 2'd2,
        CMD_REPORT   = 2'd3
    } t_cmd;

    // data handed from one row cell to the next as the column wave moves down
    typedef struct packed {
        t_val  fresh;  // new value of the row above
        t_val  diag;   // old value of the row above
        t_char a0;     // a char of the row above
        logic  av0;    // row above is a real row of a
        t_char a1;     // a char two rows up
        logic  av1;
        t_val  b1_0;   // back-one column, row above
        t_val  b2_0;   // back-two column, row above
        t_val  b1_1;   // back-one column, two rows up
        t_val  b2_1;   // back-two column, two rows up
        t_val  b1_2;   // back-one column, three rows up
    } t_tok;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic  clr;
        logic  wr_a;
        t_char wr_char;
        t_val  len_a;
        t_char c;
        t_char p1;
        t_char p2;
        logic  ge1;
        logic  ge2;
    } t_ctl;

    function automatic logic [DIST_W-1:0] sat_dist(input t_val val);
        logic [31:0] w;
        w = 32'(val);
        return (w > 32'd31) ? DIST_W'(31) : w[DIST_W-1:0];
    endfunction

endpackage

// File: src/edit_distance_with_swaps.sv
`timescale 1ns / 1ps

// Edit distance with adjacent and skewed swaps between word A and word B, up to
// MAX_LEN (16) characters each. Commands: clear (both words, errors), append a
// character to A, append a character to B, report. A is held in a chain of 16
// row cells, one per character; each B character sends one column wave down the
// chain, one cell per clock, so an append to B holds off the next command until
// the wave has run the length of the cell chain. A report yields one transfer on
// the output channel with the distance, the flag distance <= threshold and the
// sticky error flag (a character dropped because a word was full or because A
// was appended after B started). The threshold register may be written at any
// time the block is idle.

module edit_distance_with_swaps (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_char_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_distance,
    output logic        o_within_res,
    output logic        o_error,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data
);

    localparam int MAX_LEN = edws_pkg::MAX_LEN;
    localparam int VAL_W   = edws_pkg::VAL_W;

    // control registers
    logic [edws_pkg::THR_W-1:0] r_threshold;
    edws_pkg::t_val             r_len_a, n_len_a;
    edws_pkg::t_val             r_len_b, n_len_b;
    edws_pkg::t_char            r_rc0, n_rc0;   // newest b char
    edws_pkg::t_char            r_rc1, n_rc1;
    edws_pkg::t_char            r_rc2, n_rc2;
    logic                       r_err, n_err;
    edws_pkg::t_val             r_wave, n_wave; // cycles left in the column wave
    logic                       r_head_vld, n_head_vld;
    edws_pkg::t_tok             r_head_tok, n_head_tok;

    // output register
    logic                       r_out_vld, n_out_vld;
    logic [edws_pkg::DIST_W-1:0] r_out_dist, n_out_dist;
    logic                       r_out_within, n_out_within;
    logic                       r_out_err, n_out_err;

    logic            in_xfer;
    edws_pkg::t_cmd  cmd;
    logic            a_ok;
    logic            b_ok;
    edws_pkg::t_val  cur_dist;
    edws_pkg::t_ctl  ctl;

    logic            tok_vld [0:MAX_LEN];
    edws_pkg::t_tok  tok     [0:MAX_LEN];
    edws_pkg::t_val  col_now [0:MAX_LEN];

    assign cmd     = edws_pkg::t_cmd'(i_cmd);
    assign o_ready = (r_wave == '0) && (!r_out_vld || i_ready);
    assign in_xfer = i_valid && o_ready;

    // a may only grow before b starts, and neither past MAX_LEN
    assign a_ok = (r_len_b == '0) && (r_len_a != VAL_W'(MAX_LEN));
    assign b_ok = (r_len_b != VAL_W'(MAX_LEN));

    // the distance is the last live row of the current column; row 0 is len_b
    assign cur_dist = col_now[r_len_a];

    // broadcast to the cells; during a wave r_len_b already counts the new char
    always_comb begin
        ctl.clr     = in_xfer && (cmd == edws_pkg::CMD_CLEAR);
        ctl.wr_a    = in_xfer && (cmd == edws_pkg::CMD_APPEND_A) && a_ok;
        ctl.wr_char = i_char_in;
        ctl.len_a   = r_len_a;
        ctl.c       = r_rc0;
        ctl.p1      = r_rc1;
        ctl.p2      = r_rc2;
        ctl.ge1     = (r_len_b >= VAL_W'(2));
        ctl.ge2     = (r_len_b >= VAL_W'(3));
    end

    always_comb begin
        n_len_a      = r_len_a;
        n_len_b      = r_len_b;
        n_rc0        = r_rc0;
        n_rc1        = r_rc1;
        n_rc2        = r_rc2;
        n_err        = r_err;
        n_wave       = (r_wave != '0) ? r_wave - VAL_W'(1) : r_wave;
        n_head_vld   = 1'b0;
        n_head_tok   = r_head_tok;
        n_out_vld    = r_out_vld && !i_ready;
        n_out_dist   = r_out_dist;
        n_out_within = r_out_within;
        n_out_err    = r_out_err;
        if (in_xfer) begin
            unique case (cmd)
                edws_pkg::CMD_CLEAR: begin
                    n_len_a = '0;
                    n_len_b = '0;
                    n_rc0   = '0;
                    n_rc1   = '0;
                    n_rc2   = '0;
                    n_err   = 1'b0;
                end
                edws_pkg::CMD_APPEND_A: begin
                    if (a_ok) begin
                        n_len_a = r_len_a + VAL_W'(1);
                    end else begin
                        n_err = 1'b1;
                    end
                end
                edws_pkg::CMD_APPEND_B: begin
                    if (b_ok) begin
                        n_len_b    = r_len_b + VAL_W'(1);
                        n_rc0      = i_char_in;
                        n_rc1      = r_rc0;
                        n_rc2      = r_rc1;
                        n_wave     = VAL_W'(MAX_LEN);
                        n_head_vld = 1'b1;
                        // column 0 row: old value len_b, new value len_b + 1
                        n_head_tok.fresh = r_len_b + VAL_W'(1);
                        n_head_tok.diag  = r_len_b;
                        n_head_tok.a0    = '0;
                        n_head_tok.av0   = 1'b0;
                        n_head_tok.a1    = '0;
                        n_head_tok.av1   = 1'b0;
                        n_head_tok.b1_0  = r_len_b - VAL_W'(1);
                        n_head_tok.b2_0  = r_len_b - VAL_W'(2);
                        n_head_tok.b1_1  = '0;
                        n_head_tok.b2_1  = '0;
                        n_head_tok.b1_2  = '0;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                edws_pkg::CMD_REPORT: begin
                    n_out_vld    = 1'b1;
                    n_out_dist   = edws_pkg::sat_dist(cur_dist);
                    n_out_within = (32'(cur_dist) <= 32'(r_threshold));
                    n_out_err    = r_err;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_len_a     <= '0;
            r_len_b     <= '0;
            r_rc0       <= '0;
            r_rc1       <= '0;
            r_rc2       <= '0;
            r_err       <= 1'b0;
            r_wave      <= '0;
            r_head_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
            r_len_a    <= n_len_a;
            r_len_b    <= n_len_b;
            r_rc0      <= n_rc0;
            r_rc1      <= n_rc1;
            r_rc2      <= n_rc2;
            r_err      <= n_err;
            r_wave     <= n_wave;
            r_head_vld <= n_head_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_head_tok   <= n_head_tok;
        r_out_dist   <= n_out_dist;
        r_out_within <= n_out_within;
        r_out_err    <= n_out_err;
    end

    // chain of row cells, row 0 is the head register
    assign tok_vld[0] = r_head_vld;
    assign tok[0]     = r_head_tok;
    assign col_now[0] = r_len_b;

    for (genvar k = 1; k <= MAX_LEN; k++) begin : g_row
        edws_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (VAL_W'(k)),
            .i_ctl     (ctl),
            .i_tok_vld (tok_vld[k-1]),
            .i_tok     (tok[k-1]),
            .o_tok_vld (tok_vld[k]),
            .o_tok     (tok[k]),
            .o_now     (col_now[k])
        );
    end

    assign o_valid      = r_out_vld;
    assign o_distance   = r_out_dist;
    assign o_within_res = r_out_within;
    assign o_error      = r_out_err;

    // only one column wave is ever in flight
    logic [MAX_LEN:0] wave_bits;
    always_comb begin
        for (int k = 0; k <= MAX_LEN; k++) begin
            wave_bits[k] = tok_vld[k];
        end
    end

    a_one_wave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(wave_bits))
        else $error("more than one column wave in the cell chain");

    a_len_a_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len_a <= VAL_W'(MAX_LEN) && r_len_b <= VAL_W'(MAX_LEN))
        else $error("word length beyond MAX_LEN");

    a_b_starts_wave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && cmd == edws_pkg::CMD_APPEND_B && b_ok |=> r_head_vld && r_wave != '0)
        else $error("append to b did not launch a column wave");

    a_a_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && cmd == edws_pkg::CMD_APPEND_A && r_len_b != '0 |=> $stable(r_len_a) && r_err)
        else $error("append to a after b started was not dropped");

    a_busy_no_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_vld |-> !in_xfer)
        else $error("transfer taken while a column wave starts");

endmodule

// File: src/edws_cell.sv
`timescale 1ns / 1ps

module edws_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  edws_pkg::t_val     i_idx,
    input  edws_pkg::t_ctl     i_ctl,
    input  logic               i_tok_vld,
    input  edws_pkg::t_tok     i_tok,
    output logic               o_tok_vld,
    output edws_pkg::t_tok     o_tok,
    output edws_pkg::t_val     o_now
);

    edws_pkg::t_val  r_now;
    edws_pkg::t_val  r_b1;
    edws_pkg::t_val  r_b2;
    edws_pkg::t_char r_a;
    logic            r_tok_vld;
    edws_pkg::t_tok  r_tok;

    edws_pkg::t_val  n_now;
    edws_pkg::t_val  min_a;
    edws_pkg::t_cand v;
    edws_pkg::t_cand cand;
    logic            active;
    logic            load;

    assign active = (i_idx <= i_ctl.len_a);
    assign load   = i_ctl.wr_a &&
                    ({1'b0, i_idx} == ({1'b0, i_ctl.len_a} + (edws_pkg::VAL_W + 1)'(1)));

    // one cell of the distance column
    always_comb begin
        min_a = (r_now < i_tok.fresh) ? r_now : i_tok.fresh;
        min_a = (min_a < i_tok.diag) ? min_a : i_tok.diag;
        if (r_a == i_ctl.c) begin
            v = edws_pkg::CAND_W'(i_tok.diag);
        end else begin
            v = edws_pkg::CAND_W'(min_a) + edws_pkg::CAND_W'(1);
        end
        // adjacent swap
        cand = edws_pkg::CAND_W'(i_tok.b1_1) + edws_pkg::CAND_W'(1);
        if (i_tok.av0 && i_ctl.ge1 && i_tok.a0 == i_ctl.c && r_a == i_ctl.p1 && cand < v) begin
            v = cand;
        end
        // skewed swap, b side two back
        cand = edws_pkg::CAND_W'(i_tok.b2_1) + edws_pkg::CAND_W'(2);
        if (i_tok.av0 && i_ctl.ge2 && i_tok.a0 == i_ctl.c && r_a == i_ctl.p2 && cand < v) begin
            v = cand;
        end
        // skewed swap, a side two back
        cand = edws_pkg::CAND_W'(i_tok.b1_2) + edws_pkg::CAND_W'(2);
        if (i_tok.av1 && i_ctl.ge1 && r_a == i_ctl.p1 && i_tok.a1 == i_ctl.c && cand < v) begin
            v = cand;
        end
        n_now = active ? v[edws_pkg::VAL_W-1:0] : r_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_now     <= i_idx;
            r_b1      <= '0;
            r_b2      <= '0;
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok_vld;
            if (i_tok_vld) begin
                r_now <= n_now;
                r_b1  <= r_now;
                r_b2  <= r_b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_a <= i_ctl.wr_char;
        end
        if (i_tok_vld) begin
            r_tok.fresh <= n_now;
            r_tok.diag  <= r_now;
            r_tok.a0    <= r_a;
            r_tok.av0   <= 1'b1;
            r_tok.a1    <= i_tok.a0;
            r_tok.av1   <= i_tok.av0;
            r_tok.b1_0  <= r_b1;
            r_tok.b2_0  <= r_b2;
            r_tok.b1_1  <= i_tok.b1_0;
            r_tok.b2_1  <= i_tok.b2_0;
            r_tok.b1_2  <= i_tok.b1_1;
        end
    end

    assign o_tok_vld = r_tok_vld;
    assign o_tok     = r_tok;
    assign o_now     = r_now;

endmodule
